/* rtl/kvs_pkg.sv */
// Shared types, codes and defaults for the keyframe vec3 sampler.
// No dependencies; kvs_lerp and the top level import this package.
package kvs_pkg;

  localparam int unsigned MAX_KEYS_DEF  = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned KIDX_W        = 6;
  localparam int unsigned KCOUNT_W      = 7;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 7;

  // action field
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // interp_mode register
  localparam logic MODE_STEP   = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 1'b1;

  // component 0 is x, 1 is y, 2 is z
  typedef logic [2:0][VAL_W-1:0] kvs_vec_t;

  typedef struct packed {
    logic [TIME_W-1:0] ktime;
    kvs_vec_t          value;
  } kvs_entry_t;

  typedef struct packed {
    logic                     action;
    logic [KIDX_W-1:0]        key_index;
    logic [TIME_W-1:0]        key_time;
    logic signed [VAL_W-1:0]  value_x;
    logic signed [VAL_W-1:0]  value_y;
    logic signed [VAL_W-1:0]  value_z;
    logic [TIME_W-1:0]        query_time;
  } kvs_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic signed [VAL_W-1:0]  out_z;
    logic [KIDX_W-1:0]        found_index;
  } kvs_out_t;

  // request from the scan sequencer to the interpolation unit
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] qtime;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    kvs_vec_t          a;
    kvs_vec_t          b;
  } kvs_lerp_req_t;

endpackage

/* rtl/kvs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the keyframe table.
module kvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kvs_lerp.sv */
// Interpolation unit: restoring divide for the blend fraction, then one shared
// subtract / multiply / add path stepped over the three components. Uses kvs_pkg.
module kvs_lerp #(
  parameter int unsigned FRAC_BITS = kvs_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kvs_pkg::kvs_lerp_req_t req_i,
  output logic                  done_o,
  output kvs_pkg::kvs_vec_t     res_o
);
  import kvs_pkg::*;

  localparam int unsigned STEP_W = $clog2(FRAC_BITS);
  localparam int unsigned DIFF_W = VAL_W + 1;
  localparam int unsigned PROD_W = FRAC_BITS + 1 + DIFF_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_BITS - 1);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_DIV  = 3'd1;
  localparam logic [2:0] L_DIFF = 3'd2;
  localparam logic [2:0] L_MUL  = 3'd3;
  localparam logic [2:0] L_ADD  = 3'd4;
  localparam logic [2:0] L_DONE = 3'd5;

  localparam logic [1:0] COMP_LAST = 2'd2;

  logic [2:0]               state_q, state_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [1:0]               comp_q, comp_d;
  logic [TIME_W-1:0]        rem_q, rem_d;
  logic [TIME_W-1:0]        span_q, span_d;
  logic [FRAC_BITS-1:0]     k_q, k_d;
  kvs_vec_t                 a_q, a_d;
  kvs_vec_t                 b_q, b_d;
  kvs_vec_t                 res_q, res_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic [TIME_W:0]          rem_sh;
  logic [TIME_W:0]          rem_sub;
  logic                     rem_ge;
  logic signed [VAL_W-1:0]  a_c, b_c;
  logic signed [PROD_W-1:0] prod_sh;

  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_ge  = rem_sh >= {1'b0, span_q};
    rem_sub = rem_sh - {1'b0, span_q};
    a_c     = $signed(a_q[comp_q]);
    b_c     = $signed(b_q[comp_q]);
    prod_sh = prod_q >>> FRAC_BITS;

    state_d = state_q;
    step_d  = step_q;
    comp_d  = comp_q;
    rem_d   = rem_q;
    span_d  = span_q;
    k_d     = k_q;
    a_d     = a_q;
    b_d     = b_q;
    res_d   = res_q;
    diff_d  = diff_q;
    prod_d  = prod_q;

    unique case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          // t0 <= q < t1, so the fraction stays below one
          rem_d   = req_i.qtime - req_i.t0;
          span_d  = req_i.t1 - req_i.t0;
          k_d     = '0;
          step_d  = '0;
          a_d     = req_i.a;
          b_d     = req_i.b;
          state_d = L_DIV;
        end
      end
      L_DIV: begin
        rem_d  = rem_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        k_d    = {k_q[FRAC_BITS-2:0], rem_ge};
        step_d = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          comp_d  = '0;
          state_d = L_DIFF;
        end
      end
      L_DIFF: begin
        diff_d  = {b_c[VAL_W-1], b_c} - {a_c[VAL_W-1], a_c};
        state_d = L_MUL;
      end
      L_MUL: begin
        prod_d  = $signed({1'b0, k_q}) * diff_q;
        state_d = L_ADD;
      end
      L_ADD: begin
        // arithmetic shift floors toward minus infinity
        res_d[comp_q] = a_q[comp_q] + prod_sh[VAL_W-1:0];
        if (comp_q == COMP_LAST) begin
          state_d = L_DONE;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = L_DIFF;
        end
      end
      L_DONE: begin
        state_d = L_IDLE;
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    span_q <= span_d;
    k_q    <= k_d;
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    diff_q <= diff_d;
    prod_q <= prod_d;
  end

  assign done_o = state_q == L_DONE;
  assign res_o  = res_q;

endmodule

/* rtl/keyframe_vec3_sampler_top.sv */
// Top level of the keyframe vec3 sampler: config registers, table scan
// sequencer and output register. Uses kvs_pkg, kvs_ram and kvs_lerp.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------
//   in      | in_valid_i / in_stall_o   | in_data_i  (kvs_in_t)
//   out     | out_valid_o / out_stall_i | out_data_o (kvs_out_t)
//   cfg     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A load transaction writes the table in the cycle it is accepted.
// A sample scans the n keys in use with one table read per cycle on the single
// RAM read port; linear mode then adds the bit-serial divide and the shared
// multiply over x, y, z.
// Reset clears control state only; table entries hold garbage until loaded.
// A finished result waits in the output register while a new transaction is taken.
module keyframe_vec3_sampler_top #(
  parameter int unsigned MAX_KEYS  = kvs_pkg::MAX_KEYS_DEF,
  parameter int unsigned FRAC_BITS = kvs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  kvs_pkg::kvs_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output kvs_pkg::kvs_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [kvs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [kvs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import kvs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_LERP_GO   = 3'd2;
  localparam logic [2:0] S_LERP_WAIT = 3'd3;
  localparam logic [2:0] S_FINISH    = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                mode_q;
  logic [KCOUNT_W-1:0] kcount_q;
  logic [TIME_W-1:0]   qtime_q, qtime_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic                cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]    found_q, found_d;
  kvs_entry_t          lo_q, lo_d;
  kvs_entry_t          hi_q, hi_d;
  kvs_vec_t            res_q, res_d;
  logic                out_valid_q, out_valid_d;
  kvs_out_t            out_data_q, out_data_d;

  logic                in_accept;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  kvs_entry_t          ram_wdata;
  logic                ram_re;
  kvs_entry_t          ram_rdata;
  logic [31:0]         kidx32;
  logic [31:0]         n32;
  logic [31:0]         found32;
  logic                q_before;
  logic                at_last;

  kvs_lerp_req_t       lerp_req;
  logic                lerp_done;
  kvs_vec_t            lerp_res;

  assign in_stall_o = state_q != S_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;

  // table write straight from the accepted load transaction
  assign kidx32          = 32'(in_data_i.key_index);
  assign ram_we          = in_accept && (in_data_i.action == ACT_LOAD) && (kidx32 < MAX_KEYS);
  assign ram_waddr       = kidx32[IDX_W-1:0];
  assign ram_wdata.ktime = in_data_i.key_time;
  assign ram_wdata.value = {in_data_i.value_z, in_data_i.value_y, in_data_i.value_x};

  assign ram_re = (state_q == S_SCAN) && (rd_idx_q < n_q);

  kvs_ram #(
    .WIDTH ($bits(kvs_entry_t)),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign lerp_req.start = state_q == S_LERP_GO;
  assign lerp_req.qtime = qtime_q;
  assign lerp_req.t0    = lo_q.ktime;
  assign lerp_req.t1    = hi_q.ktime;
  assign lerp_req.a     = lo_q.value;
  assign lerp_req.b     = hi_q.value;

  kvs_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .done_o (lerp_done),
    .res_o  (lerp_res)
  );

  // effective key count: zero counts as one, saturate at table depth
  always_comb begin
    if (kcount_q == '0) begin
      n32 = 32'd1;
    end else if (32'(kcount_q) > MAX_KEYS) begin
      n32 = 32'(MAX_KEYS);
    end else begin
      n32 = 32'(kcount_q);
    end
  end

  assign q_before = qtime_q < ram_rdata.ktime;
  assign at_last  = CNT_W'(cmp_idx_q) == (n_q - 1'b1);
  assign found32  = 32'(found_q);

  always_comb begin
    state_d     = state_q;
    qtime_d     = qtime_q;
    n_d         = n_q;
    rd_idx_d    = rd_idx_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (in_data_i.action == ACT_SAMPLE)) begin
          qtime_d  = in_data_i.query_time;
          n_d      = n32[CNT_W-1:0];
          rd_idx_d = '0;
          found_d  = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        // one read issued per cycle; the compare follows in the next cycle
        if (ram_re) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
        end
        if (cmp_v_q) begin
          if (q_before && (cmp_idx_q == '0)) begin
            // query before the first key: hold entry 0
            found_d = '0;
            res_d   = ram_rdata.value;
            cmp_v_d = 1'b0;
            state_d = S_FINISH;
          end else if (q_before) begin
            found_d = cmp_idx_q - 1'b1;
            hi_d    = ram_rdata;
            res_d   = lo_q.value;
            cmp_v_d = 1'b0;
            state_d = (mode_q == MODE_LINEAR) ? S_LERP_GO : S_FINISH;
          end else if (at_last) begin
            found_d = cmp_idx_q;
            res_d   = ram_rdata.value;
            cmp_v_d = 1'b0;
            state_d = S_FINISH;
          end else begin
            lo_d = ram_rdata;
          end
        end
      end
      S_LERP_GO: begin
        state_d = S_LERP_WAIT;
      end
      S_LERP_WAIT: begin
        if (lerp_done) begin
          res_d   = lerp_res;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_data_d.out_x       = $signed(res_q[0]);
          out_data_d.out_y       = $signed(res_q[1]);
          out_data_d.out_z       = $signed(res_q[2]);
          out_data_d.found_index = found32[KIDX_W-1:0];
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_LINEAR;
      kcount_q    <= KCOUNT_W'(1);
      rd_idx_q    <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_INTERP_MODE: mode_q   <= cfg_wdata_i[0];
          CFG_KEY_COUNT:   kcount_q <= cfg_wdata_i[KCOUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qtime_q    <= qtime_d;
    n_q        <= n_d;
    cmp_idx_q  <= cmp_idx_d;
    found_q    <= found_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_sample_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.action == ACT_SAMPLE) |=> state_q == S_SCAN)
    else $error("accepted sample did not start a scan");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_v_q |-> 32'(cmp_idx_q) < 32'(n_q))
    else $error("scan compared an entry beyond the key count");

  a_lerp_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lerp_done |-> state_q == S_LERP_WAIT)
    else $error("interpolation finished while not awaited");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result appeared without a finished sample");
`endif

endmodule
